// ----- design/src_pkg.sv -----
package src_pkg;

    // Coordinate and fraction widths of the clipper
    localparam int COORD_BITS = 24;
    localparam int T_BITS     = 16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_right;
        logic signed [COORD_BITS-1:0] rect_top;
        logic signed [COORD_BITS-1:0] rect_bottom;
    } t_seg_req;

    typedef struct packed {
        logic                         visible;
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
    } t_clip_res;

endpackage

// ----- design/segment_rect_clipper.sv -----
// Liang-Barsky segment clipper. A request (segment plus rectangle) is taken in
// every cycle that start is high; busy never rises. Each request gives exactly
// one result on o_result, marked by o_valid for one cycle, after it has passed
// stages A and B, the divider stages, and stages E to H. The edge-parameter
// divider resolves one quotient bit per pipeline stage for all four rectangle
// edges at once. Results cannot be held off.
module segment_rect_clipper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  src_pkg::t_seg_req i_req,
    output logic              o_valid,
    output src_pkg::t_clip_res o_result
);
    import src_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int T   = T_BITS;
    localparam int RW  = C + 3;          // divider remainder width
    localparam int QW  = T + 2;          // raw quotient width
    localparam int TW  = T + 3;          // signed edge parameter width
    localparam int PW  = T + C + 3;      // product width
    localparam int DS  = T + 2;          // divider stages
    localparam int LAT = T + 8;
    localparam logic [QW-1:0]     T_SAT  = QW'((1 << T) + 1);
    localparam logic [T:0]        T_ONE  = (T+1)'(1 << T);
    localparam logic signed [PW-1:0] RND = PW'((1 << T) - 1);

    // ---------------- stage A: edge terms ----------------
    logic                r_a_v;
    logic signed [C:0]   r_a_p [4];
    logic signed [C:0]   r_a_q [4];
    t_seg_req            r_a_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_seg  <= i_req;
        r_a_p[0] <= (C+1)'(i_req.start_x) - (C+1)'(i_req.end_x);
        r_a_p[1] <= (C+1)'(i_req.end_x) - (C+1)'(i_req.start_x);
        r_a_p[2] <= (C+1)'(i_req.start_y) - (C+1)'(i_req.end_y);
        r_a_p[3] <= (C+1)'(i_req.end_y) - (C+1)'(i_req.start_y);
        r_a_q[0] <= (C+1)'(i_req.start_x) - (C+1)'(i_req.rect_left);
        r_a_q[1] <= (C+1)'(i_req.rect_right) - (C+1)'(i_req.start_x);
        r_a_q[2] <= (C+1)'(i_req.start_y) - (C+1)'(i_req.rect_top);
        r_a_q[3] <= (C+1)'(i_req.rect_bottom) - (C+1)'(i_req.start_y);
    end

    // ---------------- divider pipeline: one quotient bit per stage ----------------
    logic                r_dv   [DS+1];
    t_seg_req            r_dseg [DS+1];
    logic [C:0]          r_ap   [DS+1][4];
    logic [RW-1:0]       r_rem  [DS+1][4];
    logic [QW-1:0]       r_quo  [DS+1][4];
    logic                r_sat  [DS+1][4];
    logic                r_pz   [DS+1][4];
    logic                r_pn   [DS+1][4];
    logic                r_qn   [DS+1][4];

    // Stage B: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dseg[0] <= r_a_seg;
        for (int i = 0; i < 4; i++) begin
            r_ap[0][i]  <= r_a_p[i][C] ? (C+1)'(-r_a_p[i]) : r_a_p[i];
            r_rem[0][i] <= RW'(r_a_q[i][C] ? (C+1)'(-r_a_q[i]) : r_a_q[i]);
            r_quo[0][i] <= '0;
            r_sat[0][i] <= 1'b0;
            r_pz[0][i]  <= (r_a_p[i] == '0);
            r_pn[0][i]  <= r_a_p[i][C];
            r_qn[0][i]  <= r_a_q[i][C];
        end
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
        logic [RW-1:0] n_rem [4];
        logic          n_bit [4];
        logic          n_sat [4];

        // Compare and subtract the shifted divisor
        always_comb begin
            for (int i = 0; i < 4; i++) begin
                logic [RW-1:0] v_rs;
                logic [RW-1:0] v_dv;
                v_rs = (j >= 2) ? {r_rem[j][i][RW-2:0], 1'b0} : r_rem[j][i];
                v_dv = (j == 0) ? {1'b0, r_ap[j][i], 1'b0} : {2'b00, r_ap[j][i]};
                n_bit[i] = (v_rs >= v_dv);
                n_rem[i] = n_bit[i] ? v_rs - v_dv : v_rs;
                n_sat[i] = (j == 0) ? (r_rem[j][i] >= {r_ap[j][i], 2'b00})
                                    : r_sat[j][i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dseg[j+1] <= r_dseg[j];
            for (int i = 0; i < 4; i++) begin
                r_ap[j+1][i]  <= r_ap[j][i];
                r_rem[j+1][i] <= n_rem[i];
                r_quo[j+1][i] <= {r_quo[j][i][QW-2:0], n_bit[i]};
                r_sat[j+1][i] <= n_sat[i];
                r_pz[j+1][i]  <= r_pz[j][i];
                r_pn[j+1][i]  <= r_pn[j][i];
                r_qn[j+1][i]  <= r_qn[j][i];
            end
        end
    end

    // ---------------- stage E: signed, saturated edge parameter ----------------
    logic                r_e_v;
    t_seg_req            r_e_seg;
    logic signed [TW-1:0] r_e_t [4];
    logic                r_e_pz [4];
    logic                r_e_pn [4];
    logic                r_e_qn [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_seg <= r_dseg[DS];
        for (int i = 0; i < 4; i++) begin
            logic [QW-1:0] v_m;
            v_m = (r_sat[DS][i] || r_quo[DS][i] > T_SAT) ? T_SAT : r_quo[DS][i];
            r_e_t[i]  <= (r_pn[DS][i] ^ r_qn[DS][i]) ? -signed'(TW'(v_m))
                                                      : signed'(TW'(v_m));
            r_e_pz[i] <= r_pz[DS][i];
            r_e_pn[i] <= r_pn[DS][i];
            r_e_qn[i] <= r_qn[DS][i];
        end
    end

    // ---------------- stage F: narrow entry and exit bounds ----------------
    logic                r_f_v;
    t_seg_req            r_f_seg;
    logic                r_f_vis;
    logic [T:0]          r_f_t0;
    logic [T:0]          r_f_t1;
    logic signed [C:0]   r_f_dx;
    logic signed [C:0]   r_f_dy;
    logic                n_vis;
    logic signed [TW-1:0] n_t0;
    logic signed [TW-1:0] n_t1;

    always_comb begin
        n_vis = 1'b1;
        n_t0  = '0;
        n_t1  = signed'(TW'(T_ONE));
        for (int i = 0; i < 4; i++) begin
            if (n_vis) begin
                if (r_e_pz[i]) begin
                    if (r_e_qn[i]) begin
                        n_vis = 1'b0;
                    end
                end else if (r_e_pn[i]) begin
                    if (r_e_t[i] > n_t1) begin
                        n_vis = 1'b0;
                    end else if (r_e_t[i] > n_t0) begin
                        n_t0 = r_e_t[i];
                    end
                end else begin
                    if (r_e_t[i] < n_t0) begin
                        n_vis = 1'b0;
                    end else if (r_e_t[i] < n_t1) begin
                        n_t1 = r_e_t[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_seg <= r_e_seg;
        r_f_vis <= n_vis;
        r_f_t0  <= n_t0[T:0];
        r_f_t1  <= n_t1[T:0];
        r_f_dx  <= (C+1)'(r_e_seg.end_x) - (C+1)'(r_e_seg.start_x);
        r_f_dy  <= (C+1)'(r_e_seg.end_y) - (C+1)'(r_e_seg.start_y);
    end

    // ---------------- stage G: scale deltas by the bounds ----------------
    logic                r_g_v;
    t_seg_req            r_g_seg;
    logic                r_g_vis;
    logic signed [PW-1:0] r_g_prod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_seg     <= r_f_seg;
        r_g_vis     <= r_f_vis;
        r_g_prod[0] <= signed'({1'b0, r_f_t0}) * r_f_dx;
        r_g_prod[1] <= signed'({1'b0, r_f_t0}) * r_f_dy;
        r_g_prod[2] <= signed'({1'b0, r_f_t1}) * r_f_dx;
        r_g_prod[3] <= signed'({1'b0, r_f_t1}) * r_f_dy;
    end

    // ---------------- stage H: truncate toward zero, move endpoints ----------------
    logic      r_h_v;
    t_clip_res r_h_res;
    logic signed [C-1:0] n_mv [4];
    logic signed [C-1:0] n_base [4];

    always_comb begin
        n_base[0] = r_g_seg.start_x;
        n_base[1] = r_g_seg.start_y;
        n_base[2] = r_g_seg.start_x;
        n_base[3] = r_g_seg.start_y;
        for (int i = 0; i < 4; i++) begin
            logic signed [PW-1:0] v_adj;
            v_adj   = r_g_prod[i] + (r_g_prod[i][PW-1] ? RND : PW'(0));
            v_adj   = v_adj >>> T;
            n_mv[i] = C'(v_adj) + n_base[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_res.visible <= r_g_vis;
        if (r_g_vis) begin
            r_h_res.clip_start_x <= n_mv[0];
            r_h_res.clip_start_y <= n_mv[1];
            r_h_res.clip_end_x   <= n_mv[2];
            r_h_res.clip_end_y   <= n_mv[3];
        end else begin
            r_h_res.clip_start_x <= r_g_seg.start_x;
            r_h_res.clip_start_y <= r_g_seg.start_y;
            r_h_res.clip_end_x   <= r_g_seg.end_x;
            r_h_res.clip_end_y   <= r_g_seg.end_y;
        end
    end

    assign busy     = 1'b0;
    assign o_valid  = r_h_v;
    assign o_result = r_h_res;

    // ---------------- checks ----------------
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("clipper raised busy");

    a_reject_keeps_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.visible) |->
            (o_result.clip_start_x == $past(i_req.start_x, LAT)) &&
            (o_result.clip_end_y == $past(i_req.end_y, LAT)))
        else $error("rejected segment lost its endpoints");

    a_direction_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.visible &&
         $past(i_req.start_x, LAT) <= $past(i_req.end_x, LAT)) |->
            (o_result.clip_start_x <= o_result.clip_end_x))
        else $error("clipped segment reversed its direction");

endmodule
